[design/tetrahedron_face_vectors_volume_core_defines.svh]
// Assertion macros shared by the tetrahedron face vector design.
`ifndef TETRAHEDRON_FACE_VECTORS_VOLUME_CORE_DEFINES_SVH
`define TETRAHEDRON_FACE_VECTORS_VOLUME_CORE_DEFINES_SVH

// The condition implies the property in the same cycle.
`define TFVV_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tfvv: same-cycle check failed");

// The condition implies the property in the next cycle.
`define TFVV_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tfvv: next-cycle check failed");

`endif

[design/tfvv_pkg.sv]
package tfvv_pkg;

  localparam int COORD_IN_W = 16;
  localparam int N_CORNER   = 4;
  localparam int N_AXIS     = 3;
  localparam int N_COORD    = N_CORNER * N_AXIS;
  localparam int AREA_W     = 34;
  localparam int VOL_W      = 51;
  localparam int FACE_W     = 2;
  localparam int IN_DEPTH   = 2;
  localparam int IN_PTR_W   = 1;
  localparam int IN_CNT_W   = 2;
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PTR_W  = 3;
  localparam int OUT_CNT_W  = 4;

  typedef logic [FACE_W-1:0] face_t;

  localparam face_t FIRST_FACE = 2'd0;
  localparam face_t LAST_FACE  = 2'd3;

  typedef struct packed {
    face_t                    face_index;
    logic signed [AREA_W-1:0] area2_x;
    logic signed [AREA_W-1:0] area2_y;
    logic signed [AREA_W-1:0] area2_z;
    logic [VOL_W-1:0]         volume6;
    logic                     last;
  } res_t;

endpackage

[design/tetrahedron_face_vectors_volume_core.sv]
// Takes the four corners of a tetrahedron per request and returns four face results, for the
// faces opposite corners 0 to 3 in that order, each with the outward face vector times two and
// six times the volume; the fourth result has last set. A request is taken into a two-entry
// input queue and its four faces then enter a single shared arithmetic pipeline one per cycle
// while the result queue has room for them, so all faces of one request issue before the next
// request starts. An eight-entry result queue holds finished faces while pop is low; the
// pipeline only starts a face that has a slot reserved in it.
`include "tetrahedron_face_vectors_volume_core_defines.svh"

module tetrahedron_face_vectors_volume_core import tfvv_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [COORD_IN_W-1:0]    n0_x,
  input  logic [COORD_IN_W-1:0]    n0_y,
  input  logic [COORD_IN_W-1:0]    n0_z,
  input  logic [COORD_IN_W-1:0]    n1_x,
  input  logic [COORD_IN_W-1:0]    n1_y,
  input  logic [COORD_IN_W-1:0]    n1_z,
  input  logic [COORD_IN_W-1:0]    n2_x,
  input  logic [COORD_IN_W-1:0]    n2_y,
  input  logic [COORD_IN_W-1:0]    n2_z,
  input  logic [COORD_IN_W-1:0]    n3_x,
  input  logic [COORD_IN_W-1:0]    n3_y,
  input  logic [COORD_IN_W-1:0]    n3_z,
  output logic                     empty,
  input  logic                     pop,
  output logic [FACE_W-1:0]        face_index,
  output logic signed [AREA_W-1:0] area2_x,
  output logic signed [AREA_W-1:0] area2_y,
  output logic signed [AREA_W-1:0] area2_z,
  output logic [VOL_W-1:0]         volume6,
  output logic                     last
);

  logic                           head_valid;
  logic [N_COORD*COORD_WIDTH-1:0] head_coords;
  logic                           head_pop;
  logic [OUT_CNT_W-1:0]           out_count;
  logic                           res_push;
  res_t                           res;
  res_t                           head;

  tfvv_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .n0_x       (n0_x),
    .n0_y       (n0_y),
    .n0_z       (n0_z),
    .n1_x       (n1_x),
    .n1_y       (n1_y),
    .n1_z       (n1_z),
    .n2_x       (n2_x),
    .n2_y       (n2_y),
    .n2_z       (n2_z),
    .n3_x       (n3_x),
    .n3_y       (n3_y),
    .n3_z       (n3_z),
    .head_valid (head_valid),
    .head_coords(head_coords),
    .head_pop   (head_pop)
  );

  tfvv_face_pipe #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_face_pipe (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_coords(head_coords),
    .head_pop   (head_pop),
    .out_count  (out_count),
    .res_push   (res_push),
    .res        (res)
  );

  tfvv_out_fifo u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .res_push(res_push),
    .res     (res),
    .pop     (pop),
    .empty   (empty),
    .head    (head),
    .count   (out_count)
  );

  assign face_index = head.face_index;
  assign area2_x    = head.area2_x;
  assign area2_y    = head.area2_y;
  assign area2_z    = head.area2_z;
  assign volume6    = head.volume6;
  assign last       = head.last;

  `TFVV_ASSERT_IMP(a_out_no_overflow, clk, rst, res_push, out_count != OUT_CNT_W'(OUT_DEPTH))
  `TFVV_ASSERT_NXT(a_in_taken_visible, clk, rst, push && !full, head_valid)
  `TFVV_ASSERT_IMP(a_last_on_final_face, clk, rst, !empty, last == (face_index == LAST_FACE))

endmodule

[design/tfvv_front.sv]
module tfvv_front import tfvv_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [COORD_IN_W-1:0]             n0_x,
  input  logic [COORD_IN_W-1:0]             n0_y,
  input  logic [COORD_IN_W-1:0]             n0_z,
  input  logic [COORD_IN_W-1:0]             n1_x,
  input  logic [COORD_IN_W-1:0]             n1_y,
  input  logic [COORD_IN_W-1:0]             n1_z,
  input  logic [COORD_IN_W-1:0]             n2_x,
  input  logic [COORD_IN_W-1:0]             n2_y,
  input  logic [COORD_IN_W-1:0]             n2_z,
  input  logic [COORD_IN_W-1:0]             n3_x,
  input  logic [COORD_IN_W-1:0]             n3_y,
  input  logic [COORD_IN_W-1:0]             n3_z,
  output logic                              head_valid,
  output logic [N_COORD*COORD_WIDTH-1:0]    head_coords,
  input  logic                              head_pop
);

  localparam int CW = COORD_WIDTH;

  logic [N_COORD*CW-1:0] coords_in;
  logic [N_COORD*CW-1:0] q [IN_DEPTH];
  logic [IN_PTR_W-1:0]   wr_ptr;
  logic [IN_PTR_W-1:0]   rd_ptr;
  logic [IN_CNT_W-1:0]   cnt;
  logic                  accept;
  logic                  take;

  // Only the low COORD_WIDTH bits of each coordinate are kept.
  assign coords_in = {n3_z[CW-1:0], n3_y[CW-1:0], n3_x[CW-1:0],
                      n2_z[CW-1:0], n2_y[CW-1:0], n2_x[CW-1:0],
                      n1_z[CW-1:0], n1_y[CW-1:0], n1_x[CW-1:0],
                      n0_z[CW-1:0], n0_y[CW-1:0], n0_x[CW-1:0]};

  assign full        = (cnt == IN_CNT_W'(IN_DEPTH));
  assign head_valid  = (cnt != '0);
  assign head_coords = q[rd_ptr];
  assign accept      = push && !full;
  assign take        = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (accept && !take) begin
        cnt <= cnt + 1'b1;
      end else if (take && !accept) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= coords_in;
    end
  end

endmodule

[design/tfvv_face_pipe.sv]
module tfvv_face_pipe import tfvv_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  logic [N_COORD*COORD_WIDTH-1:0] head_coords,
  output logic                           head_pop,
  input  logic [OUT_CNT_W-1:0]           out_count,
  output logic                           res_push,
  output res_t                           res
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int QW = PW + DW;
  localparam int SW = QW + 2;
  localparam int RW = OUT_CNT_W + 1;

  logic signed [CW-1:0] corner [N_CORNER][N_AXIS];
  logic [1:0]           sel_b;
  logic [1:0]           sel_p;
  logic [1:0]           sel_q;
  logic [1:0]           sel_o;
  logic [RW-1:0]        reserved;
  logic                 issue;
  face_t                face;

  logic                 v1, v2, v3, v4;
  face_t                f1, f2, f3, f4;
  logic signed [DW-1:0] e1 [N_AXIS];
  logic signed [DW-1:0] e2 [N_AXIS];
  logic signed [DW-1:0] t1 [N_AXIS];
  logic signed [PW-1:0] pr [6];
  logic signed [DW-1:0] t2 [N_AXIS];
  logic signed [PW-1:0] cr [N_AXIS];
  logic signed [DW-1:0] t3 [N_AXIS];
  logic signed [QW-1:0] dq [N_AXIS];
  logic signed [PW-1:0] cr4 [N_AXIS];

  logic signed [SW-1:0] dot;
  logic signed [SW-1:0] mag;
  logic                 flip;
  logic signed [PW-1:0] area [N_AXIS];

  always_comb begin
    for (int c = 0; c < N_CORNER; c++) begin
      for (int a = 0; a < N_AXIS; a++) begin
        corner[c][a] = head_coords[(c*N_AXIS + a)*CW +: CW];
      end
    end
  end

  // Base corner, the two far corners of the face, and the opposite corner.
  always_comb begin
    case (face)
      2'd0: begin
        sel_b = 2'd1; sel_p = 2'd2; sel_q = 2'd3; sel_o = 2'd0;
      end
      2'd1: begin
        sel_b = 2'd0; sel_p = 2'd2; sel_q = 2'd3; sel_o = 2'd1;
      end
      2'd2: begin
        sel_b = 2'd0; sel_p = 2'd1; sel_q = 2'd3; sel_o = 2'd2;
      end
      default: begin
        sel_b = 2'd0; sel_p = 2'd1; sel_q = 2'd2; sel_o = 2'd3;
      end
    endcase
  end

  // Every face in flight already holds a slot in the result queue.
  assign reserved = RW'(out_count) + RW'(v1) + RW'(v2) + RW'(v3) + RW'(v4);
  assign issue    = head_valid && (reserved < RW'(OUT_DEPTH));
  assign head_pop = issue && (face == LAST_FACE);

  always_ff @(posedge clk) begin
    if (rst) begin
      face <= FIRST_FACE;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
    end else begin
      if (issue) begin
        face <= face + 1'b1;
      end
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    f1 <= face;
    for (int a = 0; a < N_AXIS; a++) begin
      e1[a] <= DW'(corner[sel_p][a]) - DW'(corner[sel_b][a]);
      e2[a] <= DW'(corner[sel_q][a]) - DW'(corner[sel_b][a]);
      t1[a] <= DW'(corner[sel_o][a]) - DW'(corner[sel_b][a]);
    end

    f2    <= f1;
    pr[0] <= e1[1] * e2[2];
    pr[1] <= e1[2] * e2[1];
    pr[2] <= e1[2] * e2[0];
    pr[3] <= e1[0] * e2[2];
    pr[4] <= e1[0] * e2[1];
    pr[5] <= e1[1] * e2[0];
    t2    <= t1;

    f3    <= f2;
    cr[0] <= pr[0] - pr[1];
    cr[1] <= pr[2] - pr[3];
    cr[2] <= pr[4] - pr[5];
    t3    <= t2;

    f4 <= f3;
    for (int a = 0; a < N_AXIS; a++) begin
      dq[a] <= cr[a] * t3[a];
    end
    cr4 <= cr;
  end

  // A face vector that points toward the opposite corner is turned around.
  always_comb begin
    dot  = SW'(dq[0]) + SW'(dq[1]) + SW'(dq[2]);
    flip = !dot[SW-1] && (dot != '0);
    mag  = dot[SW-1] ? -dot : dot;
    for (int a = 0; a < N_AXIS; a++) begin
      area[a] = flip ? -cr4[a] : cr4[a];
    end
  end

  assign res_push        = v4;
  assign res.face_index  = f4;
  assign res.area2_x     = AREA_W'(area[0]);
  assign res.area2_y     = AREA_W'(area[1]);
  assign res.area2_z     = AREA_W'(area[2]);
  assign res.volume6     = VOL_W'(mag[QW-1:0]);
  assign res.last        = (f4 == LAST_FACE);

endmodule

[design/tfvv_out_fifo.sv]
module tfvv_out_fifo import tfvv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_push,
  input  res_t                 res,
  input  logic                 pop,
  output logic                 empty,
  output res_t                 head,
  output logic [OUT_CNT_W-1:0] count
);

  res_t                 mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 take;

  assign empty = (count == '0);
  assign head  = mem[rd_ptr];
  assign take  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (res_push && !take) begin
        count <= count + 1'b1;
      end else if (take && !res_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      mem[wr_ptr] <= res;
    end
  end

endmodule
